// ===== hw/rtl/sdti_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_pkg
// Shared constants, types and the sine table for the degree sine lookup.
// ----------------------------------------------------------------------------
package sdti_pkg;

	// angle and result widths
	localparam int AngleW = 16;
	localparam int SineW  = 16;
	localparam int FracW  = 8;
	localparam int IdxW   = 7;
	localparam int FoldW  = 15;   // folded angle stays within 0..90 degrees
	localparam int PointW = 15;   // table entries are at most 0x7fff
	localparam int DeltaW = 10;   // largest step between entries is 0x23c

	// angles in 8.8 fixed point
	localparam logic [AngleW-1:0] Ang180 = 16'd46080;
	localparam logic [AngleW-1:0] Ang90  = 16'd23040;
	localparam logic [IdxW-1:0]   IdxLast = 7'd90;

	// rounding constant for the interpolation shift
	localparam logic [DeltaW+FracW-1:0] RoundHalf = 18'd128;

	// result of the angle fold
	typedef struct packed {
		logic [FoldW-1:0] angle;
		logic             negate;
	} fold_t;

	// secant-optimised sine points, one per degree
	localparam logic [PointW-1:0] SinePoints [91] = '{
		15'h0000, 15'h023c, 15'h0478, 15'h06b3, 15'h08ee, 15'h0b28, 15'h0d61, 15'h0f9a,
		15'h11d1, 15'h1406, 15'h163a, 15'h186d, 15'h1a9d, 15'h1ccb, 15'h1ef8, 15'h2121,
		15'h2348, 15'h256d, 15'h278e, 15'h29ad, 15'h2bc8, 15'h2ddf, 15'h2ff4, 15'h3204,
		15'h3410, 15'h3619, 15'h381d, 15'h3a1d, 15'h3c18, 15'h3e0f, 15'h4001, 15'h41ed,
		15'h43d5, 15'h45b7, 15'h4794, 15'h496c, 15'h4b3d, 15'h4d09, 15'h4ecf, 15'h508e,
		15'h5248, 15'h53fb, 15'h55a7, 15'h574d, 15'h58eb, 15'h5a83, 15'h5c14, 15'h5d9e,
		15'h5f20, 15'h609b, 15'h620f, 15'h637a, 15'h64df, 15'h663b, 15'h678f, 15'h68db,
		15'h6a1f, 15'h6b5b, 15'h6c8e, 15'h6db9, 15'h6edb, 15'h6ff5, 15'h7106, 15'h720e,
		15'h730d, 15'h7403, 15'h74f0, 15'h75d4, 15'h76af, 15'h7781, 15'h7849, 15'h7908,
		15'h79bd, 15'h7a69, 15'h7b0c, 15'h7ba5, 15'h7c34, 15'h7cb9, 15'h7d35, 15'h7da7,
		15'h7e0f, 15'h7e6e, 15'h7ec2, 15'h7f0d, 15'h7f4e, 15'h7f85, 15'h7fb1, 15'h7fd4,
		15'h7fed, 15'h7ffc, 15'h7fff
	};

	// table read, clamped to the last entry
	function automatic logic [PointW-1:0] sine_point(input logic [IdxW-1:0] idx);
		logic [IdxW-1:0] safe;
		safe = (idx > IdxLast) ? IdxLast : idx;
		return SinePoints[safe];
	endfunction

endpackage

// ===== hw/rtl/sdti_fold.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdti_fold
// Folds an 8.8 degree angle into 0..90 degrees and flags the negative half.
// ----------------------------------------------------------------------------
module sdti_fold (
	input  logic [sdti_pkg::AngleW-1:0] angle,
	output sdti_pkg::fold_t             fold
);
	import sdti_pkg::*;

	logic [AngleW-1:0] half;
	logic              upper;
	logic [AngleW-1:0] mirrored;

	// lower half-turn, with the negate flag for the upper one
	assign upper = (angle >= Ang180);
	assign half  = upper ? (angle - Ang180) : angle;

	// mirror the second quadrant onto the first
	assign mirrored = (half > Ang90) ? (Ang180 - half) : half;

	assign fold.angle  = mirrored[FoldW-1:0];
	assign fold.negate = upper;

endmodule

// ===== hw/rtl/sine_degrees_table_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_degrees_table_interp
// Sine of an 8.8 fixed-point angle in degrees, returned in signed Q1.15,
// by a 91-point table and linear interpolation on the angle fraction.
//
//   channel  signals                          beat carries
//   input    angle_valid / angle_stall        angle, 8.8 degrees, unsigned
//   output   sine_valid  / sine_stall         sine, Q1.15, signed
//
// One beat in and one beat out per clock while the output is not stalled; each
// beat is registered in turn in the fold, table read, interpolation multiply and sign stages.
// Every stage holds its own valid bit and moves on when the next is free, so
// a stall at the output fills empty stages first and loses no beat.
// angle_stall is high only when the first stage is full and cannot advance.
// Reset clears all valid bits; the block is stateless otherwise.
// ----------------------------------------------------------------------------
module sine_degrees_table_interp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        angle_valid,
	output logic                        angle_stall,
	input  logic [sdti_pkg::AngleW-1:0] angle,
	output logic                        sine_valid,
	input  logic                        sine_stall,
	output logic [sdti_pkg::SineW-1:0]  sine
);
	import sdti_pkg::*;

	fold_t fold;

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4;

	fold_t               fold_s1;
	logic [PointW-1:0]   lo_s2, lo_s3;
	logic [DeltaW-1:0]   delta_s2;
	logic [FracW-1:0]    frac_s2;
	logic                neg_s2, neg_s3;
	logic [DeltaW-1:0]   corr_s3;
	logic [SineW-1:0]    sine_s4;

	logic [IdxW-1:0]         idx;
	logic [PointW-1:0]       lo_pt, hi_pt;
	logic [DeltaW+FracW-1:0] prod;
	logic [SineW-1:0]        mag;

	// stage readiness, back from the output
	assign rdy_s4 = !valid_s4 || !sine_stall;
	assign rdy_s3 = !valid_s3 || rdy_s4;
	assign rdy_s2 = !valid_s2 || rdy_s3;
	assign rdy_s1 = !valid_s1 || rdy_s2;
	assign angle_stall = !rdy_s1;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (rdy_s1) valid_s1 <= angle_valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			if (rdy_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: fold into the first quadrant
	sdti_fold u_fold (
		.angle (angle),
		.fold  (fold)
	);

	always_ff @(posedge clk) begin
		if (rdy_s1 && angle_valid) begin
			fold_s1 <= fold;
		end
	end

	// stage 2: read the two neighbouring table points
	assign idx   = fold_s1.angle[FoldW-1:FracW];
	assign lo_pt = sine_point(idx);
	assign hi_pt = (idx < IdxLast) ? sine_point(idx + 7'd1) : lo_pt;

	always_ff @(posedge clk) begin
		if (rdy_s2 && valid_s1) begin
			lo_s2    <= lo_pt;
			delta_s2 <= DeltaW'(hi_pt - lo_pt);
			frac_s2  <= fold_s1.angle[FracW-1:0];
			neg_s2   <= fold_s1.negate;
		end
	end

	// stage 3: scale the step by the fraction, rounded
	assign prod = ({{FracW{1'b0}}, delta_s2} * {{DeltaW{1'b0}}, frac_s2}) + RoundHalf;

	always_ff @(posedge clk) begin
		if (rdy_s3 && valid_s2) begin
			corr_s3 <= prod[DeltaW+FracW-1:FracW];
			lo_s3   <= lo_s2;
			neg_s3  <= neg_s2;
		end
	end

	// stage 4: add and apply the sign
	assign mag = {1'b0, lo_s3} + {{(SineW-DeltaW){1'b0}}, corr_s3};

	always_ff @(posedge clk) begin
		if (rdy_s4 && valid_s3) begin
			sine_s4 <= neg_s3 ? SineW'(~mag + 16'd1) : mag;
		end
	end

	assign sine_valid = valid_s4;
	assign sine       = sine_s4;

	// the input is held off only while the first stage is occupied
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		angle_stall |-> valid_s1)
		else $error("input stalled with an empty first stage");

	// the magnitude never reaches full scale
	a_no_min: assert property (@(posedge clk) disable iff (!arst_n)
		sine_valid |-> (sine != 16'h8000))
		else $error("sine result at negative full scale");

	// a stalled output beat stays put until taken
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(sine_valid && sine_stall) |=> (sine_valid && $stable(sine)))
		else $error("stalled output beat changed");

	// a beat held in stage 3 never vanishes while stage 4 waits
	a_s3_keep: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && !rdy_s4) |=> valid_s3)
		else $error("stage 3 beat lost during stall");

endmodule

// ===== test/sine_degrees_table_interp_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sine_degrees_table_interp_tb
// Self-checking bench for the degree sine lookup. Angles are sent as beats
// on a valid/stall channel and every returned sine beat is compared with a
// local model of the fold, table read and rounded interpolation. A directed
// set of corner angles comes first, then about 1500 random angles under
// three patterns of sender and receiver idling.
// ----------------------------------------------------------------------------
module sine_degrees_table_interp_tb;

	import sdti_pkg::*;

	localparam int RandomAngles = 1500;
	localparam int CycleLimit   = 200000;
	localparam int DrainCycles  = 12;
	localparam int ShownErrors  = 10;

	// 8.8 degree landmarks
	localparam logic [15:0] Deg90  = 16'h5a00;
	localparam logic [15:0] Deg180 = 16'hb400;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                angle_valid = 1'b0;
	logic                angle_stall;
	logic [AngleW-1:0]   angle       = '0;
	logic                sine_valid;
	logic                sine_stall  = 1'b0;
	logic [SineW-1:0]    sine;

	// per-degree secant points, one more than the last degree
	logic [15:0] degree_points [91] = '{
		16'h0000, 16'h023c, 16'h0478, 16'h06b3, 16'h08ee, 16'h0b28, 16'h0d61, 16'h0f9a,
		16'h11d1, 16'h1406, 16'h163a, 16'h186d, 16'h1a9d, 16'h1ccb, 16'h1ef8, 16'h2121,
		16'h2348, 16'h256d, 16'h278e, 16'h29ad, 16'h2bc8, 16'h2ddf, 16'h2ff4, 16'h3204,
		16'h3410, 16'h3619, 16'h381d, 16'h3a1d, 16'h3c18, 16'h3e0f, 16'h4001, 16'h41ed,
		16'h43d5, 16'h45b7, 16'h4794, 16'h496c, 16'h4b3d, 16'h4d09, 16'h4ecf, 16'h508e,
		16'h5248, 16'h53fb, 16'h55a7, 16'h574d, 16'h58eb, 16'h5a83, 16'h5c14, 16'h5d9e,
		16'h5f20, 16'h609b, 16'h620f, 16'h637a, 16'h64df, 16'h663b, 16'h678f, 16'h68db,
		16'h6a1f, 16'h6b5b, 16'h6c8e, 16'h6db9, 16'h6edb, 16'h6ff5, 16'h7106, 16'h720e,
		16'h730d, 16'h7403, 16'h74f0, 16'h75d4, 16'h76af, 16'h7781, 16'h7849, 16'h7908,
		16'h79bd, 16'h7a69, 16'h7b0c, 16'h7ba5, 16'h7c34, 16'h7cb9, 16'h7d35, 16'h7da7,
		16'h7e0f, 16'h7e6e, 16'h7ec2, 16'h7f0d, 16'h7f4e, 16'h7f85, 16'h7fb1, 16'h7fd4,
		16'h7fed, 16'h7ffc, 16'h7fff
	};

	logic [AngleW-1:0] angle_backlog [$];
	logic [SineW-1:0]  expected_sine [$];
	logic [AngleW-1:0] expected_angle [$];

	int  angles_total   = 0;
	int  angles_sent    = 0;
	int  angles_taken   = 0;
	int  upper_taken    = 0;
	int  sines_checked  = 0;
	int  error_count    = 0;
	int  cycle_count    = 0;
	bit  angle_taken_now = 1'b0;

	sine_degrees_table_interp u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.angle_valid (angle_valid),
		.angle_stall (angle_stall),
		.angle       (angle),
		.sine_valid  (sine_valid),
		.sine_stall  (sine_stall),
		.sine        (sine)
	);

	// fold to 0..90, interpolate with +128 rounding, then apply the sign
	function automatic logic [SineW-1:0] sine_of_angle(input logic [AngleW-1:0] a);
		int unsigned folded;
		int unsigned deg;
		int unsigned frac;
		int unsigned lo;
		int unsigned hi;
		int unsigned mag;
		bit          negate;
		folded = a;
		negate = 1'b0;
		if (folded >= Deg180) begin
			folded = folded - Deg180;
			negate = 1'b1;
		end
		if (folded > Deg90)
			folded = Deg180 - folded;
		deg  = folded >> 8;
		frac = folded & 8'hff;
		lo   = degree_points[deg];
		hi   = (deg < 90) ? degree_points[deg + 1] : lo;
		mag  = lo + ((((hi - lo) * frac) + 128) >> 8);
		if (negate)
			mag = (0 - mag) & 16'hffff;
		return mag[SineW-1:0];
	endfunction

	// random angle, weighted towards the fold boundaries, fraction extremes and midpoint, and the upper half-turn
	function automatic logic [AngleW-1:0] random_angle();
		int unsigned pick;
		int unsigned deg;
		logic [15:0] a;
		pick = $urandom_range(99);
		if (pick < 45) begin
			a = $urandom_range(16'hffff);
		end else if (pick < 65) begin
			case ($urandom_range(3))
				0: a = Deg90 - 16'($urandom_range(300));
				1: a = Deg90 + 16'($urandom_range(300));
				2: a = Deg180 - 16'($urandom_range(300));
				default: a = Deg180 + 16'($urandom_range(300));
			endcase
		end else if (pick < 85) begin
			deg = $urandom_range(255);
			case ($urandom_range(3))
				0: a = {8'(deg), 8'h00};
				1: a = {8'(deg), 8'h80};
				2: a = {8'(deg), 8'hff};
				default: a = {8'(deg), 8'h7f};
			endcase
		end else begin
			a = 16'($urandom_range(16'hffff, Deg180));
		end
		return a;
	endfunction

	// clock
	always #1 clk = ~clk;

	// cycle guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d sines still awaited",
				cycle_count, expected_sine.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// driver: offer angle beats and drive the receiver stall at the falling edge
	always @(negedge clk) begin
		int send_idle;
		int recv_idle;
		if (arst_n) begin
			if (angles_sent < angles_total / 3) begin
				send_idle = 8;
				recv_idle = 62;
			end else if (angles_sent < (2 * angles_total) / 3) begin
				send_idle = 62;
				recv_idle = 8;
			end else begin
				send_idle = 0;
				recv_idle = 0;
			end
			if (!angle_valid || angle_taken_now) begin
				if (angle_backlog.size() > 0 && $urandom_range(99) >= send_idle) begin
					angle       <= angle_backlog.pop_front();
					angle_valid <= 1'b1;
					angles_sent++;
				end else begin
					angle_valid <= 1'b0;
				end
			end
			sine_stall <= ($urandom_range(99) < recv_idle);
		end
	end

	// monitor: predict on accepted angle beats, check accepted sine beats
	always @(posedge clk) begin
		logic [SineW-1:0]  want;
		logic [AngleW-1:0] from_angle;
		angle_taken_now = arst_n && angle_valid && !angle_stall;
		if (angle_taken_now) begin
			expected_sine.push_back(sine_of_angle(angle));
			expected_angle.push_back(angle);
			angles_taken++;
			if (angle >= Deg180)
				upper_taken++;
		end
		if (arst_n && sine_valid && !sine_stall) begin
			if (expected_sine.size() == 0) begin
				error_count++;
				if (error_count <= ShownErrors)
					$display("unexpected sine beat %h at cycle %0d", sine, cycle_count);
			end else begin
				want       = expected_sine.pop_front();
				from_angle = expected_angle.pop_front();
				sines_checked++;
				if (sine !== want) begin
					error_count++;
					if (error_count <= ShownErrors)
						$display("sine mismatch for angle %h: expected %h, got %h",
							from_angle, want, sine);
				end
			end
		end
	end

	// stimulus, reset and end of run
	initial begin
		logic [AngleW-1:0] corner [$];
		corner = '{
			16'h0000, 16'h0001, 16'h0080, 16'h00ff, 16'h0180, 16'h1e80,
			16'h59ff, Deg90, 16'h5a01, 16'h8000, 16'h7fff, 16'hb3ff,
			Deg180, 16'hb401, 16'hb480, 16'h0e00, 16'hfe00, 16'hff00,
			16'hffff, 16'haaaa, 16'h5555, 16'h0eff, 16'h3c00, 16'hcd00
		};
		foreach (corner[i])
			angle_backlog.push_back(corner[i]);
		for (int i = 0; i < RandomAngles; i++)
			angle_backlog.push_back(random_angle());
		angles_total = angle_backlog.size();

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (angle_backlog.size() == 0 && angles_taken == angles_total);
		wait (expected_sine.size() == 0);
		repeat (DrainCycles) @(posedge clk);

		$display("angles sent: %0d (%0d from 180 degrees up), sines checked: %0d",
			angles_taken, upper_taken, sines_checked);
		$display("idling covered slow receiver, slow sender and back-to-back beats");
		if (error_count == 0 && expected_sine.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d errors", error_count);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/sdti_pkg.sv
hw/rtl/sdti_fold.sv
hw/rtl/sine_degrees_table_interp.sv
test/sine_degrees_table_interp_tb.sv
